// ----- rtl/wma_pkg.sv -----
// Shared types, constants and helper functions for the workout metrics accumulator.
package wma_pkg;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Session modes
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_STARTING = 2'd1;
    localparam logic [1:0] MODE_RUNNING  = 2'd2;

    // Speed limits in hundredths of km/h
    localparam logic [11:0] SPEED_MAX = 12'd2500;
    localparam logic [11:0] SPEED_MIN = 12'd20;

    // Tick time limit and substitute, in ms
    localparam logic [15:0] DT_LIMIT = 16'd2000;
    localparam logic [10:0] DT_SUBST = 11'd200;

    // Carry units
    localparam logic [11:0] MS_PER_SEC = 12'd1000;
    localparam logic [37:0] KCAL_UNIT  = 38'd36000000000;

    // Body weight after reset
    localparam logic [7:0] WEIGHT_RESET = 8'd70;

    typedef struct packed {
        logic        command;
        logic [1:0]  session_mode;
        logic [15:0] delta_ms;
        logic        status_valid;
        logic [15:0] actual_speed;
        logic [15:0] drive_target_speed;
        logic        run_feedback;
        logic        run_command;
        logic        drive_in_run_state;
        logic [15:0] fallback_speed;
    } wma_tick_t;

    typedef struct packed {
        logic [31:0] elapsed_seconds;
        logic [47:0] distance_units;
        logic [31:0] calories_whole;
        logic [35:0] calorie_remainder;
        logic [11:0] current_speed;
        logic        refresh_request;
    } wma_metrics_t;

    // Clamp a raw 16-bit speed to the belt maximum
    function automatic logic [11:0] clamp_speed(input logic [15:0] raw);
        logic [11:0] res;
        if (raw > {4'd0, SPEED_MAX})
        begin
            res = SPEED_MAX;
        end
        else
        begin
            res = raw[11:0];
        end
        return res;
    endfunction

    // Calorie coefficient per speed band, hundredths per kg per km
    function automatic logic [6:0] band_coeff(input logic [11:0] spd);
        logic [6:0] res;
        if (spd < 12'd400)
        begin
            res = 7'd70;
        end
        else if (spd < 12'd600)
        begin
            res = 7'd80;
        end
        else if (spd < 12'd800)
        begin
            res = 7'd90;
        end
        else if (spd < 12'd1000)
        begin
            res = 7'd98;
        end
        else
        begin
            res = 7'd105;
        end
        return res;
    endfunction

endpackage

// ----- rtl/wma_if.sv -----
// Valid/ready channel interfaces for tick items and metrics results.
interface wma_tick_if
    import wma_pkg::*;
();
    logic      valid;
    logic      ready;
    wma_tick_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wma_metrics_if
    import wma_pkg::*;
();
    logic         valid;
    logic         ready;
    wma_metrics_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/workout_metrics_accumulator.sv -----
// Workout metrics accumulator: session distance, time and calorie totals per tick.
//
// Each tick or clear item gives exactly one metrics result. The block takes one item at
// a time: a clear item or a tick outside the running mode goes straight to ST_DONE; a
// running tick runs three products through one shared 31x12 multiplier (speed times ms,
// times body weight, times band coefficient), then reduces the millisecond and calorie
// carries by compare-and-subtract, one whole second and one whole kcal per cycle. A
// finished result waits in the output register while the next item is taken in. The user
// must write body weight through weight_we/weight_wdata only while idle (not enforced).
module workout_metrics_accumulator
    import wma_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           weight_we,
    input  logic [7:0]     weight_wdata,
    wma_tick_if.sink       tick_in,
    wma_metrics_if.source  metrics_out
);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_DIST = 3'd1;
    localparam logic [2:0] ST_MUL_WT   = 3'd2;
    localparam logic [2:0] ST_MUL_COEF = 3'd3;
    localparam logic [2:0] ST_REDUCE   = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [7:0]   weight_reg;
    logic [1:0]   prev_mode_reg, prev_mode_next;
    logic [11:0]  millis_reg, millis_next;
    logic [31:0]  seconds_reg, seconds_next;
    logic [47:0]  distance_reg, distance_next;
    logic [37:0]  carry_reg, carry_next;
    logic [31:0]  calories_reg, calories_next;
    logic [11:0]  speed_reg, speed_next;
    logic         refresh_reg, refresh_next;
    logic [10:0]  dt_reg, dt_next;
    logic [22:0]  dd_reg, dd_next;
    logic [30:0]  mp_reg, mp_next;
    logic         out_valid_reg, out_valid_next;
    wma_metrics_t out_payload_reg, out_payload_next;

    // Shared multiplier
    logic [30:0]  mul_a;
    logic [11:0]  mul_b;
    logic [42:0]  mul_p;

    logic         accept;
    wma_tick_t    tk;
    logic [11:0]  act_spd;
    logic [11:0]  tgt_spd;
    logic         run_hint;
    logic [11:0]  chosen_spd;
    logic [48:0]  dist_sum;
    logic         cal_ge;
    logic         ms_ge;

    assign tk      = tick_in.payload;
    assign accept  = tick_in.valid && tick_in.ready;
    assign tick_in.ready = (state_reg == ST_IDLE);

    assign metrics_out.valid   = out_valid_reg;
    assign metrics_out.payload = out_payload_reg;

    // Pick the effective speed from the drive snapshot
    assign act_spd  = clamp_speed(tk.actual_speed);
    assign tgt_spd  = clamp_speed(tk.drive_target_speed);
    assign run_hint = tk.run_feedback || tk.run_command || tk.drive_in_run_state;

    always_comb
    begin
        if (!tk.status_valid)
        begin
            chosen_spd = clamp_speed(tk.fallback_speed);
        end
        else if (act_spd >= SPEED_MIN)
        begin
            chosen_spd = act_spd;
        end
        else if (run_hint && (tgt_spd >= SPEED_MIN))
        begin
            chosen_spd = tgt_spd;
        end
        else
        begin
            chosen_spd = 12'd0;
        end
    end

    // Steer the multiplier operands by sequencer step
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_DIST:
            begin
                mul_a = {19'd0, speed_reg};
                mul_b = {1'b0, dt_reg};
            end
            ST_MUL_WT:
            begin
                mul_a = {8'd0, dd_reg};
                mul_b = {4'd0, weight_reg};
            end
            ST_MUL_COEF:
            begin
                mul_a = mp_reg;
                mul_b = {5'd0, band_coeff(speed_reg)};
            end
            default:
            begin
                mul_a = 31'd0;
                mul_b = 12'd0;
            end
        endcase
    end

    assign mul_p    = {12'd0, mul_a} * {31'd0, mul_b};
    assign dist_sum = {1'b0, distance_reg} + {26'd0, dd_reg};
    assign cal_ge   = (carry_reg >= KCAL_UNIT);
    assign ms_ge    = (millis_reg >= MS_PER_SEC);

    // Sequence one item
    always_comb
    begin
        state_next       = state_reg;
        prev_mode_next   = prev_mode_reg;
        millis_next      = millis_reg;
        seconds_next     = seconds_reg;
        distance_next    = distance_reg;
        carry_next       = carry_reg;
        calories_next    = calories_reg;
        speed_next       = speed_reg;
        refresh_next     = refresh_reg;
        dt_next          = dt_reg;
        dd_next          = dd_reg;
        mp_next          = mp_reg;
        out_valid_next   = out_valid_reg;
        out_payload_next = out_payload_reg;

        // Drop the result once its transfer completes
        if (out_valid_reg && metrics_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dt_next      = (tk.delta_ms > DT_LIMIT) ? DT_SUBST : tk.delta_ms[10:0];
                    refresh_next = 1'b0;
                    if (tk.command == CMD_CLEAR)
                    begin
                        seconds_next  = 32'd0;
                        distance_next = 48'd0;
                        calories_next = 32'd0;
                        carry_next    = 38'd0;
                        millis_next   = 12'd0;
                        speed_next    = 12'd0;
                        refresh_next  = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        if (tk.session_mode != prev_mode_reg)
                        begin
                            if (tk.session_mode == MODE_IDLE)
                            begin
                                speed_next = 12'd0;
                            end
                            prev_mode_next = tk.session_mode;
                            refresh_next   = 1'b1;
                        end
                        if ((tk.session_mode == MODE_STARTING) ||
                            (tk.session_mode == MODE_RUNNING))
                        begin
                            speed_next = chosen_spd;
                        end
                        if (tk.session_mode == MODE_RUNNING)
                        begin
                            if (tk.session_mode != prev_mode_reg)
                            begin
                                millis_next = 12'd0;
                                carry_next  = 38'd0;
                            end
                            refresh_next = 1'b1;
                            state_next   = ST_MUL_DIST;
                        end
                        else
                        begin
                            millis_next = 12'd0;
                            carry_next  = 38'd0;
                            state_next  = ST_DONE;
                        end
                    end
                end
            end
            ST_MUL_DIST:
            begin
                dd_next     = mul_p[22:0];
                millis_next = millis_reg + {1'b0, dt_reg};
                state_next  = ST_MUL_WT;
            end
            ST_MUL_WT:
            begin
                mp_next       = mul_p[30:0];
                distance_next = dist_sum[48] ? '1 : dist_sum[47:0];
                state_next    = ST_MUL_COEF;
            end
            ST_MUL_COEF:
            begin
                carry_next = carry_reg + mul_p[37:0];
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // Take one whole kcal and one whole second per cycle
                if (cal_ge)
                begin
                    carry_next    = carry_reg - KCAL_UNIT;
                    calories_next = (calories_reg == '1) ? calories_reg : calories_reg + 32'd1;
                end
                if (ms_ge)
                begin
                    millis_next  = millis_reg - MS_PER_SEC;
                    seconds_next = (seconds_reg == '1) ? seconds_reg : seconds_reg + 32'd1;
                end
                if (!cal_ge && !ms_ge)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || metrics_out.ready)
                begin
                    out_payload_next.elapsed_seconds   = seconds_reg;
                    out_payload_next.distance_units    = distance_reg;
                    out_payload_next.calories_whole    = calories_reg;
                    out_payload_next.calorie_remainder = carry_reg[35:0];
                    out_payload_next.current_speed     = speed_reg;
                    out_payload_next.refresh_request   = refresh_reg;
                    out_valid_next                     = 1'b1;
                    state_next                         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            weight_reg    <= WEIGHT_RESET;
            prev_mode_reg <= MODE_IDLE;
            millis_reg    <= 12'd0;
            seconds_reg   <= 32'd0;
            distance_reg  <= 48'd0;
            carry_reg     <= 38'd0;
            calories_reg  <= 32'd0;
            speed_reg     <= 12'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (weight_we)
            begin
                weight_reg <= weight_wdata;
            end
            prev_mode_reg <= prev_mode_next;
            millis_reg    <= millis_next;
            seconds_reg   <= seconds_next;
            distance_reg  <= distance_next;
            carry_reg     <= carry_next;
            calories_reg  <= calories_next;
            speed_reg     <= speed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working and output payload
    always_ff @(posedge clk)
    begin
        refresh_reg     <= refresh_next;
        dt_reg          <= dt_next;
        dd_reg          <= dd_next;
        mp_reg          <= mp_next;
        out_payload_reg <= out_payload_next;
    end

    // Carries are fully reduced whenever the block waits for an item
    a_millis_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (millis_reg < MS_PER_SEC))
        else $error("millisecond carry not reduced at idle");

    a_kcal_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        metrics_out.valid |-> (metrics_out.payload.calorie_remainder < KCAL_UNIT[35:0]))
        else $error("calorie remainder not below one kcal");

    a_speed_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        metrics_out.valid |-> (metrics_out.payload.current_speed <= SPEED_MAX))
        else $error("current speed above clamp");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !tick_in.ready)
        else $error("item taken while previous item in flight");

endmodule
